// ===== hdl/sscr_pkg.sv =====
// Shared types and constants for the stepper step-rate controller.
// Used by sscr_core and stepper_step_rate_controller; depends on nothing.
package sscr_pkg;

  localparam logic [15:0] INTERVAL_RESET = 16'd100;
  localparam logic [15:0] STEP_SIZE      = 16'd5;
  localparam logic [15:0] INTERVAL_MAX   = 16'hFFFF;
  localparam logic [7:0]  SPR_RESET      = 8'd48;

  // Command bytes (ASCII).
  localparam logic [7:0] CMD_SLOWER   = 8'h71; // 'q'
  localparam logic [7:0] CMD_FASTER   = 8'h77; // 'w'
  localparam logic [7:0] CMD_CONT_FWD = 8'h31; // '1'
  localparam logic [7:0] CMD_CONT_REV = 8'h32; // '2'
  localparam logic [7:0] CMD_ROT_FWD  = 8'h33; // '3'
  localparam logic [7:0] CMD_ROT_REV  = 8'h34; // '4'
  localparam logic [7:0] CMD_STOP     = 8'h30; // '0'
  localparam logic [7:0] CMD_WAVE     = 8'h61; // 'a'
  localparam logic [7:0] CMD_FULL     = 8'h73; // 's'
  localparam logic [7:0] CMD_HALF     = 8'h64; // 'd'

  // Drive-mode request codes.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_WAVE = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;
  localparam logic [1:0] MODE_HALF = 2'd3;

  typedef struct packed {
    logic [15:0] interval;
    logic [15:0] countdown;
    logic [7:0]  steps;
    logic        reverse;
    logic        single;
    logic        run;
  } ctrl_state_t;

  typedef struct packed {
    logic        step_pulse;
    logic        step_reverse;
    logic [1:0]  mode_request;
    logic        is_running;
    logic [15:0] interval_ms;
    logic [7:0]  steps_left;
  } result_t;

endpackage

// ===== hdl/sscr_core.sv =====
// Next-state and result logic for one request of the step-rate controller.
// Purely combinational; depends on sscr_pkg.
module sscr_core (
  input  sscr_pkg::ctrl_state_t cur,
  input  logic                  cmd,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            steps_per_rotation,
  output sscr_pkg::ctrl_state_t nxt,
  output sscr_pkg::result_t     res
);
  import sscr_pkg::*;

  logic [15:0] cnt_dec;
  logic        pulse;
  logic [1:0]  mode_req;

  assign cnt_dec = cur.countdown - 16'd1;

  always_comb begin
    nxt      = cur;
    pulse    = 1'b0;
    mode_req = MODE_NONE;
    if (!cmd) begin
      // A stopped tick leaves everything alone.
      if (cur.run) begin
        nxt.countdown = cnt_dec;
        if (cnt_dec == 16'd0) begin
          nxt.countdown = cur.interval;
          if (cur.single) begin
            if (cur.steps != 8'd0) begin
              nxt.steps = cur.steps - 8'd1;
              pulse     = 1'b1;
            end
          end else begin
            pulse = 1'b1;
          end
        end
      end
    end else begin
      case (rx_byte)
        CMD_SLOWER: begin
          if (cur.interval > INTERVAL_MAX - STEP_SIZE) begin
            nxt.interval = INTERVAL_MAX;
          end else begin
            nxt.interval = cur.interval + STEP_SIZE;
          end
        end
        CMD_FASTER: begin
          if (cur.interval > STEP_SIZE) begin
            nxt.interval = cur.interval - STEP_SIZE;
          end
        end
        CMD_CONT_FWD: begin
          nxt.single  = 1'b0;
          nxt.reverse = 1'b0;
          nxt.run     = 1'b1;
        end
        CMD_CONT_REV: begin
          nxt.single  = 1'b0;
          nxt.reverse = 1'b1;
          nxt.run     = 1'b1;
        end
        CMD_ROT_FWD: begin
          nxt.single  = 1'b1;
          nxt.steps   = steps_per_rotation;
          nxt.reverse = 1'b0;
          nxt.run     = 1'b1;
        end
        CMD_ROT_REV: begin
          nxt.single  = 1'b1;
          nxt.steps   = steps_per_rotation;
          nxt.reverse = 1'b1;
          nxt.run     = 1'b1;
        end
        CMD_STOP: nxt.run = 1'b0;
        CMD_WAVE: mode_req = MODE_WAVE;
        CMD_FULL: mode_req = MODE_FULL;
        CMD_HALF: mode_req = MODE_HALF;
        default: ;
      endcase
    end

    res.step_pulse   = pulse;
    res.step_reverse = pulse & cur.reverse;
    res.mode_request = mode_req;
    res.is_running   = nxt.run;
    res.interval_ms  = nxt.interval;
    res.steps_left   = nxt.steps;
  end

endmodule

// ===== hdl/stepper_step_rate_controller.sv =====
// Stepper step-rate controller: one result per request, valid in the cycle
// after input accept; one request accepted every cycle while the result
// register is empty or being drained in the same cycle.
// rst_n is synchronous, active low: interval and countdown return to 100,
// motion stops, direction forward, continuous mode, steps_per_rotation 48.
module stepper_step_rate_controller (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel: steps_per_rotation.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Input channel: one tick or one command byte per request.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_step_pulse,
  output logic        out_step_reverse,
  output logic [1:0]  out_mode_request,
  output logic        out_is_running,
  output logic [15:0] out_interval_ms,
  output logic [7:0]  out_steps_left
);
  import sscr_pkg::*;

  ctrl_state_t st_r;
  ctrl_state_t st_nxt;
  result_t     res_nxt;
  result_t     res_r;
  logic [7:0]  spr_r;
  logic        out_valid_r;
  logic        in_fire;
  logic        out_fire;

  // The configuration register can always take a write; writes are to arrive
  // only while the controller is idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  // The result register is a single stage. A new request is taken whenever
  // it is empty or its contents leave in this same cycle, so requests can
  // flow back to back at full rate.
  assign out_fire = out_valid_r & out_ready;
  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  // All of the work for one request is the short decode and update logic in
  // the core, between the controller state and the result register.
  sscr_core u_core (
    .cur                (st_r),
    .cmd                (in_cmd),
    .rx_byte            (in_rx_byte),
    .steps_per_rotation (spr_r),
    .nxt                (st_nxt),
    .res                (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r        <= SPR_RESET;
      st_r.interval  <= INTERVAL_RESET;
      st_r.countdown <= INTERVAL_RESET;
      st_r.steps     <= 8'd0;
      st_r.reverse   <= 1'b0;
      st_r.single    <= 1'b0;
      st_r.run       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        spr_r <= cfg_data;
      end
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_step_pulse   = res_r.step_pulse;
  assign out_step_reverse = res_r.step_reverse;
  assign out_mode_request = res_r.mode_request;
  assign out_is_running   = res_r.is_running;
  assign out_interval_ms  = res_r.interval_ms;
  assign out_steps_left   = res_r.steps_left;

  // The interval can never drop below the step size.
  a_interval_floor : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.interval >= STEP_SIZE)
    else $error("interval fell below the step size");

  // A reverse indication only accompanies a step pulse.
  a_reverse_needs_pulse : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_reverse |-> out_step_pulse)
    else $error("step_reverse set without step_pulse");

  // A mode request comes from a command byte, never together with a step.
  a_mode_no_pulse : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode_request != MODE_NONE) |-> !out_step_pulse)
    else $error("mode request and step pulse in one result");

  // Every accepted request yields a result in the next cycle.
  a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted request produced no result");

  // A pending result that is not taken blocks new requests.
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while result register is stalled");

endmodule

// ===== tb/sscr_rate_checker.sv =====
// Checker for the stepper step-rate controller: watches the config, request and
// result channels, predicts each status result and compares it field by field.
// Depends on sscr_pkg for the command codes, mode codes and the result layout.
module sscr_rate_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_step_pulse,
  input  logic        out_step_reverse,
  input  logic [1:0]  out_mode_request,
  input  logic        out_is_running,
  input  logic [15:0] out_interval_ms,
  input  logic [7:0]  out_steps_left,
  output int          fail_count,
  output int          outstanding,
  output int          results_checked,
  output int          pulses_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import sscr_pkg::*;

  localparam int MAX_PRINTED = 25;

  ctrl_state_t ctl;
  logic [7:0]  spr;
  result_t     status_due[$];

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) begin
      $display("%0t ns: result %0d: %s", $time, results_checked, msg);
    end
    fail_count++;
  endtask

  // Applies one request to the predicted controller state and returns the
  // status the block should report for it.
  task automatic apply_request(input logic is_cmd, input logic [7:0] code,
                               output result_t res);
    res = '0;
    if (!is_cmd) begin
      if (ctl.run) begin
        ctl.countdown = ctl.countdown - 16'd1;
        if (ctl.countdown == 16'd0) begin
          ctl.countdown = ctl.interval;
          if (!ctl.single) begin
            res.step_pulse = 1'b1;
          end else if (ctl.steps != 8'd0) begin
            ctl.steps = ctl.steps - 8'd1;
            res.step_pulse = 1'b1;
          end
          if (res.step_pulse) begin
            res.step_reverse = ctl.reverse;
          end
        end
      end
    end else begin
      case (code)
        CMD_SLOWER: begin
          if (ctl.interval > INTERVAL_MAX - STEP_SIZE) begin
            ctl.interval = INTERVAL_MAX;
          end else begin
            ctl.interval = ctl.interval + STEP_SIZE;
          end
        end
        CMD_FASTER: begin
          if (ctl.interval > STEP_SIZE) begin
            ctl.interval = ctl.interval - STEP_SIZE;
          end
        end
        CMD_CONT_FWD, CMD_CONT_REV: begin
          ctl.single  = 1'b0;
          ctl.reverse = (code == CMD_CONT_REV);
          ctl.run     = 1'b1;
        end
        CMD_ROT_FWD, CMD_ROT_REV: begin
          ctl.single  = 1'b1;
          ctl.steps   = spr;
          ctl.reverse = (code == CMD_ROT_REV);
          ctl.run     = 1'b1;
        end
        CMD_STOP: ctl.run = 1'b0;
        CMD_WAVE: res.mode_request = MODE_WAVE;
        CMD_FULL: res.mode_request = MODE_FULL;
        CMD_HALF: res.mode_request = MODE_HALF;
        default: ;
      endcase
    end
    res.is_running  = ctl.run;
    res.interval_ms = ctl.interval;
    res.steps_left  = ctl.steps;
  endtask

  always @(posedge clk) begin
    result_t predicted;
    result_t observed;
    result_t due;
    int      delta;
    if (!rst_n) begin
      ctl = '{interval: INTERVAL_RESET, countdown: INTERVAL_RESET, steps: 8'd0,
              reverse: 1'b0, single: 1'b0, run: 1'b0};
      spr = SPR_RESET;
      status_due.delete();
      outstanding <= 0;
    end else begin
      delta = 0;
      if (cfg_valid && cfg_ready) begin
        spr = cfg_data;
      end
      if (out_valid && out_ready) begin
        observed = '{out_step_pulse, out_step_reverse, out_mode_request,
                     out_is_running, out_interval_ms, out_steps_left};
        if (observed.step_pulse === 1'b1) begin
          pulses_seen++;
        end
        if (status_due.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          due = status_due.pop_front();
          delta--;
          if (observed.step_pulse !== due.step_pulse)
            report_mismatch($sformatf("step_pulse got %0b want %0b",
                                      observed.step_pulse, due.step_pulse));
          if (observed.step_reverse !== due.step_reverse)
            report_mismatch($sformatf("step_reverse got %0b want %0b",
                                      observed.step_reverse, due.step_reverse));
          if (observed.mode_request !== due.mode_request)
            report_mismatch($sformatf("mode_request got %0d want %0d",
                                      observed.mode_request, due.mode_request));
          if (observed.is_running !== due.is_running)
            report_mismatch($sformatf("is_running got %0b want %0b",
                                      observed.is_running, due.is_running));
          if (observed.interval_ms !== due.interval_ms)
            report_mismatch($sformatf("interval_ms got %0d want %0d",
                                      observed.interval_ms, due.interval_ms));
          if (observed.steps_left !== due.steps_left)
            report_mismatch($sformatf("steps_left got %0d want %0d",
                                      observed.steps_left, due.steps_left));
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_cmd, in_rx_byte, predicted);
        status_due.push_back(predicted);
        delta++;
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

// ===== tb/stepper_step_rate_controller_tb.sv =====
// Top-level testbench for stepper_step_rate_controller: drives ticks, command
// bytes and steps-per-rotation writes, and gives the verdict.
// Depends on sscr_pkg, the block itself and sscr_rate_checker.
module stepper_step_rate_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sscr_pkg::*;

  // The block answers in the cycle after a request, so a short settle after the
  // last result is plenty. The watchdog limit is several times the slowest
  // legal run, with the longest idle bursts on both sides for every request.
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int PHASE_ITEMS     = 210;
  localparam int CLIMB_ITEMS     = 60;
  localparam int CYCLE_LIMIT     = 100000;

  localparam logic [7:0] START_CODES [4] = '{CMD_CONT_FWD, CMD_CONT_REV,
                                             CMD_ROT_FWD, CMD_ROT_REV};
  localparam logic [7:0] MODE_CODES [3]  = '{CMD_WAVE, CMD_FULL, CMD_HALF};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = 8'h00;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        in_cmd     = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        out_step_pulse;
  logic        out_step_reverse;
  logic [1:0]  out_mode_request;
  logic        out_is_running;
  logic [15:0] out_interval_ms;
  logic [7:0]  out_steps_left;

  int fail_count;
  int outstanding;
  int results_checked;
  int pulses_seen;

  // Pacing controls shared by the sender and the receiver. gaps_on enables
  // random idle bursts on both sides; hold_off_req asks the receiver for one
  // long stall so the block backs up and drops in_ready.
  bit gaps_on      = 1'b1;
  bit hold_off_req = 1'b0;
  int cycle_count  = 0;
  int ticks_sent   = 0;
  int cmds_sent    = 0;
  int spr_writes   = 0;

  always #2 clk = ~clk;

  stepper_step_rate_controller uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_step_pulse   (out_step_pulse),
    .out_step_reverse (out_step_reverse),
    .out_mode_request (out_mode_request),
    .out_is_running   (out_is_running),
    .out_interval_ms  (out_interval_ms),
    .out_steps_left   (out_steps_left)
  );

  sscr_rate_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_step_pulse   (out_step_pulse),
    .out_step_reverse (out_step_reverse),
    .out_mode_request (out_mode_request),
    .out_is_running   (out_is_running),
    .out_interval_ms  (out_interval_ms),
    .out_steps_left   (out_steps_left),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .pulses_seen      (pulses_seen)
  );

  // Offers one request and returns in the time step of the edge that took it.
  // Every caller runs right after a rising edge, so all drives land as
  // nonblocking updates at that edge. When no idle gap is inserted, in_valid
  // simply stays high into the next request.
  task automatic send_request(input logic is_cmd, input logic [7:0] code);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= is_cmd;
    in_rx_byte <= code;
    if (is_cmd) cmds_sent++;
    else ticks_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly ticks, so motion actually produces pulses, with interval changes
  // leaning toward faster so the random walk spends its time at short
  // intervals. The rest are starts, stops, mode requests and arbitrary bytes.
  // A tick carries a random byte, which the block must ignore.
  task automatic send_random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) send_request(1'b0, 8'($urandom_range(0, 255)));
    else if (pick < 61) send_request(1'b1, CMD_SLOWER);
    else if (pick < 70) send_request(1'b1, CMD_FASTER);
    else if (pick < 79) send_request(1'b1, START_CODES[$urandom_range(0, 3)]);
    else if (pick < 82) send_request(1'b1, CMD_STOP);
    else if (pick < 85) send_request(1'b1, MODE_CODES[$urandom_range(0, 2)]);
    else send_request(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Stops offering and waits until every predicted result has been taken.
  // The first edge is always consumed so a request accepted in the current
  // step is already counted as outstanding.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Register writes happen only with the block idle. Every request yields a
  // result, so an empty result stream means nothing is still in flight.
  task automatic write_steps_per_rotation(input logic [7:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    spr_writes++;
  endtask

  // Receiver: ready most of the time, with short random stalls while gaps are
  // enabled, and one long stall on request. The long stall is counted here
  // while the sender keeps offering, so the block fills and stalls its input.
  initial begin
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, outstanding);
    $display("stepper_step_rate_controller_tb failed");
    $finish;
  end

  initial begin
    logic [7:0] spr_plan [8];

    // Steps-per-rotation settings for the random phases: both extremes of the
    // range, zero (a single rotation with nothing to do), a single step,
    // and a couple of random values.
    spr_plan = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd48, 8'd255, 8'd1, 8'd1};
    spr_plan[3] = 8'($urandom_range(2, 254));
    spr_plan[5] = 8'($urandom_range(2, 254));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening, still at reset settings. A tick while stopped must
    // leave the countdown alone, and unknown bytes change nothing.
    send_request(1'b0, 8'hFF);
    send_request(1'b1, 8'h00);
    send_request(1'b1, 8'hFF);
    // A tick that happens to carry a start byte is still just a tick.
    send_request(1'b0, CMD_CONT_FWD);
    send_request(1'b1, CMD_WAVE);
    send_request(1'b1, CMD_FULL);
    send_request(1'b1, CMD_HALF);
    send_request(1'b1, CMD_SLOWER);
    send_request(1'b1, CMD_FASTER);
    send_request(1'b1, CMD_FASTER);
    send_request(1'b1, CMD_CONT_FWD);
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'h00);
    // Starting again while already running must not reload the countdown.
    send_request(1'b1, CMD_CONT_REV);
    send_request(1'b0, 8'h5A);
    send_request(1'b1, CMD_STOP);
    send_request(1'b0, 8'hA5);
    // Single rotations at the reset steps-per-rotation value.
    send_request(1'b1, CMD_ROT_REV);
    send_request(1'b0, 8'h00);
    send_request(1'b1, CMD_ROT_FWD);
    send_request(1'b0, 8'h00);
    send_request(1'b1, CMD_STOP);

    // Random phases, each behind a register write made with the block idle.
    // Phase 2 runs with no idling at all; phase 4 carries the long receiver
    // stall. Each phase opens with a run of speed-ups so pulses come often.
    foreach (spr_plan[i]) begin
      gaps_on = (i != 2);
      write_steps_per_rotation(spr_plan[i]);
      if (i == 4) hold_off_req = 1'b1;
      repeat ($urandom_range(0, 25)) send_request(1'b1, CMD_FASTER);
      repeat (PHASE_ITEMS) send_random_request();
    end

    // Final part, without idling: lengthen the interval with a stream of
    // slow-downs mixed with ticks, then finish with some random traffic.
    gaps_on = 1'b0;
    write_steps_per_rotation(8'($urandom_range(1, 255)));
    send_request(1'b1, CMD_CONT_REV);
    repeat (CLIMB_ITEMS) begin
      if ($urandom_range(0, 5) == 0) send_request(1'b0, 8'($urandom_range(0, 255)));
      else send_request(1'b1, CMD_SLOWER);
    end
    repeat (40) send_random_request();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks and %0d command bytes over %0d steps-per-rotation writes",
             ticks_sent, cmds_sent, spr_writes);
    $display("%0d results checked, %0d step pulses, %0d mismatches",
             results_checked, pulses_seen, fail_count);
    if (fail_count == 0) begin
      $display("stepper_step_rate_controller_tb passed");
    end else begin
      $display("stepper_step_rate_controller_tb failed");
    end
    $finish;
  end

endmodule
